// File: design/tcve_pkg.sv
package tcve_pkg;

   // Stack depth and derived widths
   localparam int STACK_DEPTH = 32;
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

   // Result queue: one command writes at most BURST_MAX words
   localparam int BURST_MAX   = 3;
   localparam int BURST_W     = $clog2(BURST_MAX + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

   // Command codes
   typedef enum logic [2:0] {
      FUNC_FORWARD = 3'd0,
      FUNC_LEFT    = 3'd1,
      FUNC_RIGHT   = 3'd2,
      FUNC_PUSH    = 3'd3,
      FUNC_POP     = 3'd4,
      FUNC_BEGIN   = 3'd5
   } func_type;

   // Register indexes
   localparam logic [2:0] CSR_STEP_LENGTH = 3'd0;
   localparam logic [2:0] CSR_COS_TURN    = 3'd1;
   localparam logic [2:0] CSR_SIN_TURN    = 3'd2;
   localparam logic [2:0] CSR_START_X     = 3'd3;
   localparam logic [2:0] CSR_START_Y     = 3'd4;
   localparam logic [2:0] CSR_START_DIR_X = 3'd5;
   localparam logic [2:0] CSR_START_DIR_Y = 3'd6;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] dir_x;
      logic [15:0] dir_y;
   } stack_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stack_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_status_type;

   typedef struct packed {
      logic [31:0] vertex_x;
      logic [31:0] vertex_y;
      logic [7:0]  depth;
      logic        transparent;
      logic        last_of_run;
   } vertex_word_type;

endpackage

// File: design/turtle_command_vertex_engine_unit.sv
// Turtle command engine: one command word is taken per cycle when ready and
// updates the turtle state (position Q16.16, direction Q2.14), so forward
// and turn commands stream at one word per cycle. Each command's vertices go
// into a four-word result queue; a new command is taken while at most one
// word waits there, so a pop, which writes three vertices, holds the input
// while the queue drains. The saved states live in a row of 32 stack cells
// that shift down on push and up on pop; a push on a full stack and a pop
// on an empty stack or before the first vertex are dropped. Registers must
// be written only while the block is idle, which it does not check; begin
// reloads the start state from them and empties the stack.
module turtle_command_vertex_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_depth_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic [7:0]  rsp_depth_out,
   output logic        rsp_transparent,
   output logic        rsp_last_of_run,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tcve_pkg::*;

   // Configuration
   logic [15:0]        step_ff;
   logic signed [15:0] cos_ff;
   logic signed [15:0] sin_ff;
   logic [31:0]        start_x_ff;
   logic [31:0]        start_y_ff;
   logic [15:0]        start_dx_ff;
   logic [15:0]        start_dy_ff;

   // Turtle state
   logic [31:0]        pos_x_ff, pos_x_in;
   logic [31:0]        pos_y_ff, pos_y_in;
   logic signed [15:0] dir_x_ff, dir_x_in;
   logic signed [15:0] dir_y_ff, dir_y_in;
   logic [31:0]        last_x_ff, last_x_in;
   logic [31:0]        last_y_ff, last_y_in;
   logic               has_vertex_ff, has_vertex_in;

   logic               accept;
   logic               queue_room;
   logic               queue_pop;
   logic               queue_not_empty;
   vertex_word_type    queue_head;
   logic [BURST_W-1:0] burst_n;
   vertex_word_type    burst [BURST_MAX];

   stack_ctrl_type     stack_ctrl;
   stack_status_type   stack_status;
   stack_entry_type    stack_push_entry;
   stack_entry_type    stack_top;

   // Forward step products, floor shift by six
   logic signed [32:0] prod_x;
   logic signed [32:0] prod_y;
   logic signed [33:0] neg_prod_y;
   logic [31:0]        fwd_x;
   logic [31:0]        fwd_y;

   // Rotation products
   logic signed [31:0] xc, ys, xs, yc;
   logic signed [32:0] left_x, left_y, right_x, right_y;

   assign prod_x     = 33'($signed({1'b0, step_ff})) * 33'(dir_x_ff);
   assign prod_y     = 33'($signed({1'b0, step_ff})) * 33'(dir_y_ff);
   assign neg_prod_y = -{prod_y[32], prod_y};
   assign fwd_x      = pos_x_ff + {{5{prod_x[32]}}, prod_x[32:6]};
   assign fwd_y      = pos_y_ff + {{4{neg_prod_y[33]}}, neg_prod_y[33:6]};

   assign xc      = 32'(dir_x_ff) * 32'(cos_ff);
   assign ys      = 32'(dir_y_ff) * 32'(sin_ff);
   assign xs      = 32'(dir_x_ff) * 32'(sin_ff);
   assign yc      = 32'(dir_y_ff) * 32'(cos_ff);
   assign left_x  = 33'(xc) - 33'(ys);
   assign left_y  = 33'(xs) + 33'(yc);
   assign right_x = 33'(xc) + 33'(ys);
   assign right_y = 33'(yc) - 33'(xs);

   assign req_ready = queue_room;
   assign accept    = req_valid && queue_room;
   assign queue_pop = queue_not_empty && rsp_ready;

   assign stack_push_entry = '{pos_x: pos_x_ff, pos_y: pos_y_ff,
                               dir_x: dir_x_ff, dir_y: dir_y_ff};

   // Decode the command and form the next state and its vertices
   always_comb begin
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      dir_x_in      = dir_x_ff;
      dir_y_in      = dir_y_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      has_vertex_in = has_vertex_ff;
      stack_ctrl    = '0;
      burst_n       = '0;
      for (int k = 0; k < BURST_MAX; k++) begin
         burst[k] = '0;
      end
      if (accept) begin
         unique case (req_func)
            FUNC_FORWARD: begin
               pos_x_in      = fwd_x;
               pos_y_in      = fwd_y;
               last_x_in     = fwd_x;
               last_y_in     = fwd_y;
               has_vertex_in = 1'b1;
               burst[0]      = '{vertex_x: fwd_x, vertex_y: fwd_y, depth: req_depth_tag,
                                 transparent: 1'b0, last_of_run: 1'b1};
               burst_n       = BURST_W'(1);
            end
            FUNC_LEFT: begin
               dir_x_in = left_x[29:14];
               dir_y_in = left_y[29:14];
            end
            FUNC_RIGHT: begin
               dir_x_in = right_x[29:14];
               dir_y_in = right_y[29:14];
            end
            FUNC_PUSH: begin
               stack_ctrl.push = 1'b1;
            end
            FUNC_POP: begin
               if (!stack_status.empty && has_vertex_ff) begin
                  stack_ctrl.pop = 1'b1;
                  pos_x_in  = stack_top.pos_x;
                  pos_y_in  = stack_top.pos_y;
                  dir_x_in  = stack_top.dir_x;
                  dir_y_in  = stack_top.dir_y;
                  last_x_in = stack_top.pos_x;
                  last_y_in = stack_top.pos_y;
                  burst[0]  = '{vertex_x: last_x_ff, vertex_y: last_y_ff,
                                depth: req_depth_tag, transparent: 1'b1,
                                last_of_run: 1'b0};
                  burst[1]  = '{vertex_x: stack_top.pos_x, vertex_y: stack_top.pos_y,
                                depth: req_depth_tag, transparent: 1'b1,
                                last_of_run: 1'b0};
                  burst[2]  = '{vertex_x: stack_top.pos_x, vertex_y: stack_top.pos_y,
                                depth: req_depth_tag, transparent: 1'b0,
                                last_of_run: 1'b1};
                  burst_n   = BURST_W'(3);
               end
            end
            FUNC_BEGIN: begin
               pos_x_in         = start_x_ff;
               pos_y_in         = start_y_ff;
               dir_x_in         = start_dx_ff;
               dir_y_in         = start_dy_ff;
               last_x_in        = '0;
               last_y_in        = '0;
               has_vertex_in    = 1'b0;
               stack_ctrl.clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Register state; configuration writes land here too
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= 16'd256;
         cos_ff        <= 16'sd16384;
         sin_ff        <= '0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         start_dx_ff   <= 16'd16384;
         start_dy_ff   <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         dir_x_ff      <= 16'sd16384;
         dir_y_ff      <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         has_vertex_ff <= 1'b0;
      end else begin
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         dir_x_ff      <= dir_x_in;
         dir_y_ff      <= dir_y_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         has_vertex_ff <= has_vertex_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEP_LENGTH: step_ff     <= csr_wdata[15:0];
               CSR_COS_TURN:    cos_ff      <= csr_wdata[15:0];
               CSR_SIN_TURN:    sin_ff      <= csr_wdata[15:0];
               CSR_START_X:     start_x_ff  <= csr_wdata;
               CSR_START_Y:     start_y_ff  <= csr_wdata;
               CSR_START_DIR_X: start_dx_ff <= csr_wdata[15:0];
               CSR_START_DIR_Y: start_dy_ff <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   tcve_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stack_ctrl),
      .push_entry (stack_push_entry),
      .top_entry  (stack_top),
      .status     (stack_status)
   );

   tcve_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (burst_n),
      .burst     (burst),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .room      (queue_room),
      .head      (queue_head)
   );

   assign rsp_valid       = queue_not_empty;
   assign rsp_vertex_x    = queue_head.vertex_x;
   assign rsp_vertex_y    = queue_head.vertex_y;
   assign rsp_depth_out   = queue_head.depth;
   assign rsp_transparent = queue_head.transparent;
   assign rsp_last_of_run = queue_head.last_of_run;

endmodule

// File: design/tcve_stack_cell.sv
module tcve_stack_cell (
   input  logic                      clock,
   input  logic                      shift_down,
   input  logic                      shift_up,
   input  tcve_pkg::stack_entry_type from_prev,
   input  tcve_pkg::stack_entry_type from_next,
   output tcve_pkg::stack_entry_type entry
);
   import tcve_pkg::*;

   stack_entry_type entry_ff;
   stack_entry_type entry_in;

   // Take the upper neighbour on push, the lower one on pop, else hold
   always_comb begin
      priority if (shift_down) begin
         entry_in = from_prev;
      end else if (shift_up) begin
         entry_in = from_next;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: design/tcve_stack.sv
module tcve_stack (
   input  logic                       clock,
   input  logic                       reset,
   input  tcve_pkg::stack_ctrl_type   ctrl,
   input  tcve_pkg::stack_entry_type  push_entry,
   output tcve_pkg::stack_entry_type  top_entry,
   output tcve_pkg::stack_status_type status
);
   import tcve_pkg::*;

   logic [STACK_CNT_W-1:0] count_ff;
   logic [STACK_CNT_W-1:0] count_in;
   logic                   push_en;
   logic                   pop_en;
   stack_entry_type        cell_q [STACK_DEPTH];

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == STACK_CNT_W'(STACK_DEPTH));

   // Drop a push on a full stack and a pop on an empty one
   assign push_en = ctrl.push && !status.full;
   assign pop_en  = ctrl.pop && !status.empty;

   // Row of cells, top of stack in cell zero
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      stack_entry_type prev_entry;
      stack_entry_type next_entry;
      if (i == 0) begin : g_head
         assign prev_entry = push_entry;
      end else begin : g_body
         assign prev_entry = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign next_entry = cell_q[i];
      end else begin : g_inner
         assign next_entry = cell_q[i+1];
      end
      tcve_stack_cell u_cell (
         .clock      (clock),
         .shift_down (push_en),
         .shift_up   (pop_en),
         .from_prev  (prev_entry),
         .from_next  (next_entry),
         .entry      (cell_q[i])
      );
   end

   assign top_entry = cell_q[0];

   // Track fill level
   always_comb begin
      priority if (ctrl.clear) begin
         count_in = '0;
      end else if (push_en) begin
         count_in = count_ff + STACK_CNT_W'(1);
      end else if (pop_en) begin
         count_in = count_ff - STACK_CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: design/tcve_out_queue.sv
module tcve_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tcve_pkg::BURST_W-1:0]  push_n,
   input  tcve_pkg::vertex_word_type     burst [tcve_pkg::BURST_MAX],
   input  logic                          pop,
   output logic                          not_empty,
   output logic                          room,
   output tcve_pkg::vertex_word_type     head
);
   import tcve_pkg::*;

   vertex_word_type     ent_ff [QUEUE_DEPTH];
   vertex_word_type     ent_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic [QCNT_W-1:0]   cnt_pop;

   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - BURST_MAX));
   assign head      = ent_ff[0];

   // Shift out the head word, then append the new burst behind what is left
   always_comb begin
      vertex_word_type base;
      cnt_pop = pop ? count_ff - QCNT_W'(1) : count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            base = ent_ff[QIDX_W'((i + 1) % QUEUE_DEPTH)];
         end else begin
            base = ent_ff[i];
         end
         ent_in[i] = base;
         for (int k = 0; k < BURST_MAX; k++) begin
            if (BURST_W'(k) < push_n && QCNT_W'(i) == cnt_pop + QCNT_W'(k)) begin
               ent_in[i] = burst[k];
            end
         end
      end
      count_in = cnt_pop + QCNT_W'(push_n);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: sim/tb_turtle_command_vertex_engine_unit.sv
`timescale 1ns / 1ps

module tb_turtle_command_vertex_engine_unit;
   import tcve_pkg::*;

   // Codes outside the command set and the register map
   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
   localparam logic [2:0] CSR_UNUSED   = 3'd7;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 8;
   localparam int MAX_REPORTS  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_func = FUNC_FORWARD;
   logic [7:0]  req_depth_tag = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_vertex_x;
   logic [31:0] rsp_vertex_y;
   logic [7:0]  rsp_depth_out;
   logic        rsp_transparent;
   logic        rsp_last_of_run;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_STEP_LENGTH;
   logic [31:0] csr_wdata = 32'h0;

   turtle_command_vertex_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_depth_tag   (req_depth_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_depth_out   (rsp_depth_out),
      .rsp_transparent (rsp_transparent),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Shadow registers
   logic        [15:0] cfg_step     = 16'd256;
   logic signed [15:0] cfg_cos      = 16'sd16384;
   logic signed [15:0] cfg_sin      = 16'sd0;
   logic        [31:0] cfg_start_x  = 32'h0;
   logic        [31:0] cfg_start_y  = 32'h0;
   logic signed [15:0] cfg_start_dx = 16'sd16384;
   logic signed [15:0] cfg_start_dy = 16'sd0;

   // Shadow turtle state
   logic        [31:0] turtle_x     = 32'h0;
   logic        [31:0] turtle_y     = 32'h0;
   logic signed [15:0] heading_x    = 16'sd16384;
   logic signed [15:0] heading_y    = 16'sd0;
   logic        [31:0] saved_x  [STACK_DEPTH];
   logic        [31:0] saved_y  [STACK_DEPTH];
   logic        [15:0] saved_hx [STACK_DEPTH];
   logic        [15:0] saved_hy [STACK_DEPTH];
   int                 saved_count  = 0;
   logic        [31:0] prev_vx      = 32'h0;
   logic        [31:0] prev_vy      = 32'h0;
   logic               drawn        = 1'b0;

   vertex_word_type pending_vertices[$];

   bit idle_enable = 1'b1;
   int stall_left = 0;
   int cycles = 0;
   int mismatches = 0;
   int commands_sent = 0;
   int vertices_checked = 0;
   int pushes_dropped = 0;
   int pops_dropped = 0;
   int register_writes = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Cut the run short if it hangs
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[turtle_command_vertex_engine_unit] ERROR");
      $finish;
   end

   // Result side: stall in random bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted word with the oldest expected vertex
   always @(posedge clock) begin
      vertex_word_type got;
      vertex_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.vertex_x    = rsp_vertex_x;
         got.vertex_y    = rsp_vertex_y;
         got.depth       = rsp_depth_out;
         got.transparent = rsp_transparent;
         got.last_of_run = rsp_last_of_run;
         if (pending_vertices.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected vertex: x=%h y=%h depth=%h tr=%b last=%b",
                        got.vertex_x, got.vertex_y, got.depth, got.transparent,
                        got.last_of_run);
         end else begin
            want = pending_vertices.pop_front();
            vertices_checked++;
            if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
                got.depth !== want.depth || got.transparent !== want.transparent ||
                got.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"vertex mismatch: exp x=%h y=%h depth=%h tr=%b last=%b, ",
                            "got x=%h y=%h depth=%h tr=%b last=%b"},
                           want.vertex_x, want.vertex_y, want.depth, want.transparent,
                           want.last_of_run, got.vertex_x, got.vertex_y, got.depth,
                           got.transparent, got.last_of_run);
            end
         end
      end
   end

   // Queue one expected vertex
   function automatic void expect_vertex(logic [31:0] vx, logic [31:0] vy, logic [7:0] tag,
                                         logic tr, logic last);
      vertex_word_type v;
      v.vertex_x    = vx;
      v.vertex_y    = vy;
      v.depth       = tag;
      v.transparent = tr;
      v.last_of_run = last;
      pending_vertices.insert(pending_vertices.size(), v);
   endfunction

   // Rotate the heading by (cos, s), floor shift, wrap to 16 bits
   function automatic void rotate_heading(longint s);
      longint hx;
      longint hy;
      longint c;
      longint nx;
      longint ny;
      hx = longint'(heading_x);
      hy = longint'(heading_y);
      c  = longint'(cfg_cos);
      nx = (hx * c - hy * s) >>> 14;
      ny = (hx * s + hy * c) >>> 14;
      heading_x = nx[15:0];
      heading_y = ny[15:0];
   endfunction

   // Advance the shadow turtle by one command and queue its vertices
   function automatic void advance_turtle(logic [2:0] cmd, logic [7:0] tag);
      longint st;
      longint dx;
      longint dy;
      st = longint'(cfg_step);
      case (cmd)
         FUNC_FORWARD: begin
            dx = (st * longint'(heading_x)) >>> 6;
            dy = (st * -longint'(heading_y)) >>> 6;
            turtle_x = turtle_x + dx[31:0];
            turtle_y = turtle_y + dy[31:0];
            prev_vx  = turtle_x;
            prev_vy  = turtle_y;
            drawn    = 1'b1;
            expect_vertex(turtle_x, turtle_y, tag, 1'b0, 1'b1);
         end
         FUNC_LEFT:  rotate_heading(longint'(cfg_sin));
         FUNC_RIGHT: rotate_heading(-longint'(cfg_sin));
         FUNC_PUSH: begin
            if (saved_count < STACK_DEPTH) begin
               saved_x[saved_count]  = turtle_x;
               saved_y[saved_count]  = turtle_y;
               saved_hx[saved_count] = heading_x;
               saved_hy[saved_count] = heading_y;
               saved_count++;
            end else begin
               pushes_dropped++;
            end
         end
         FUNC_POP: begin
            if (saved_count == 0 || !drawn) begin
               pops_dropped++;
            end else begin
               expect_vertex(prev_vx, prev_vy, tag, 1'b1, 1'b0);
               saved_count--;
               turtle_x  = saved_x[saved_count];
               turtle_y  = saved_y[saved_count];
               heading_x = saved_hx[saved_count];
               heading_y = saved_hy[saved_count];
               expect_vertex(turtle_x, turtle_y, tag, 1'b1, 1'b0);
               expect_vertex(turtle_x, turtle_y, tag, 1'b0, 1'b1);
               prev_vx = turtle_x;
               prev_vy = turtle_y;
            end
         end
         FUNC_BEGIN: begin
            turtle_x    = cfg_start_x;
            turtle_y    = cfg_start_y;
            heading_x   = cfg_start_dx;
            heading_y   = cfg_start_dy;
            saved_count = 0;
            prev_vx     = 32'h0;
            prev_vy     = 32'h0;
            drawn       = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Send one command word, with an optional gap before it
   task automatic send_command(logic [2:0] cmd, logic [7:0] tag);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= cmd;
      req_depth_tag <= tag;
      do @(posedge clock); while (!req_ready);
      commands_sent++;
      advance_turtle(cmd, tag);
   endtask

   // Drop valid, wait for every expected vertex, then let the block settle
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Write one register and mirror it in the shadow copy
   task automatic load_register(logic [2:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      register_writes++;
      case (idx)
         CSR_STEP_LENGTH: cfg_step     = data[15:0];
         CSR_COS_TURN:    cfg_cos      = data[15:0];
         CSR_SIN_TURN:    cfg_sin      = data[15:0];
         CSR_START_X:     cfg_start_x  = data;
         CSR_START_Y:     cfg_start_y  = data;
         CSR_START_DIR_X: cfg_start_dx = data[15:0];
         CSR_START_DIR_Y: cfg_start_dy = data[15:0];
         default: ;
      endcase
   endtask

   // 16-bit register word with junk in the unused upper half
   function automatic logic [31:0] short_word(int val);
      logic [31:0] w;
      w = val;
      return {16'($urandom), w[15:0]};
   endfunction

   function automatic int rand_q14();
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 38) return FUNC_FORWARD;
      if (r < 52) return FUNC_LEFT;
      if (r < 66) return FUNC_RIGHT;
      if (r < 80) return FUNC_PUSH;
      if (r < 94) return FUNC_POP;
      if (r < 97) return FUNC_BEGIN;
      return ($urandom_range(0, 1) == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
   endfunction

   // Reset values: every command, spare codes, pops that must be dropped
   task automatic test_default_commands();
      send_command(FUNC_FORWARD, 8'h00);
      send_command(FUNC_FORWARD, 8'hFF);
      send_command(FUNC_POP, 8'h11);
      send_command(FUNC_PUSH, 8'h22);
      send_command(FUNC_LEFT, 8'h33);
      send_command(FUNC_FORWARD, 8'h44);
      send_command(FUNC_RIGHT, 8'h55);
      send_command(FUNC_POP, 8'h66);
      send_command(FUNC_SPARE_6, 8'h77);
      send_command(FUNC_SPARE_7, 8'h88);
      send_command(FUNC_BEGIN, 8'h99);
      send_command(FUNC_PUSH, 8'hAA);
      send_command(FUNC_POP, 8'hBB);
      send_command(FUNC_FORWARD, 8'hCC);
      send_command(FUNC_POP, 8'hDD);
      drain_block();
   endtask

   // Extreme register values, position wrap and heading wrap
   task automatic test_register_extremes();
      load_register(CSR_STEP_LENGTH, 32'h0000FFFF);
      load_register(CSR_COS_TURN, short_word(0));
      load_register(CSR_SIN_TURN, short_word(16384));
      load_register(CSR_START_X, 32'h7FFFFFFF);
      load_register(CSR_START_Y, 32'h80000000);
      load_register(CSR_START_DIR_X, short_word(-16384));
      load_register(CSR_START_DIR_Y, short_word(16384));
      load_register(CSR_UNUSED, $urandom);
      send_command(FUNC_BEGIN, 8'h01);
      send_command(FUNC_FORWARD, 8'h02);
      send_command(FUNC_LEFT, 8'h03);
      send_command(FUNC_FORWARD, 8'h04);
      send_command(FUNC_RIGHT, 8'h05);
      send_command(FUNC_RIGHT, 8'h06);
      send_command(FUNC_FORWARD, 8'h07);
      drain_block();
      load_register(CSR_STEP_LENGTH, 32'hFFFF0000);
      load_register(CSR_COS_TURN, short_word(-16384));
      load_register(CSR_SIN_TURN, short_word(-16384));
      send_command(FUNC_BEGIN, 8'h08);
      send_command(FUNC_FORWARD, 8'h09);
      send_command(FUNC_LEFT, 8'h0A);
      drain_block();
      // Unit cos and sin together grow the heading until it wraps
      load_register(CSR_STEP_LENGTH, 32'h00000001);
      load_register(CSR_COS_TURN, short_word(16384));
      load_register(CSR_SIN_TURN, short_word(16384));
      send_command(FUNC_LEFT, 8'h0B);
      send_command(FUNC_LEFT, 8'h0C);
      send_command(FUNC_RIGHT, 8'h0D);
      send_command(FUNC_FORWARD, 8'h0E);
      drain_block();
   endtask

   // Fill the stack past its depth, then empty it past the bottom
   task automatic test_stack_full();
      load_register(CSR_STEP_LENGTH, 32'h00000100);
      load_register(CSR_COS_TURN, short_word(15137));
      load_register(CSR_SIN_TURN, short_word(6270));
      send_command(FUNC_BEGIN, 8'($urandom));
      for (int i = 0; i < STACK_DEPTH + 2; i++) begin
         send_command(FUNC_FORWARD, 8'($urandom));
         send_command(($urandom_range(0, 1) == 0) ? FUNC_LEFT : FUNC_RIGHT, 8'($urandom));
         send_command(FUNC_PUSH, 8'($urandom));
      end
      for (int i = 0; i < STACK_DEPTH + 1; i++)
         send_command(FUNC_POP, 8'($urandom));
      drain_block();
   endtask

   // Random registers, then a stream of mostly well-formed commands
   task automatic test_random_phase(bit extremes, int count);
      if (extremes) begin
         load_register(CSR_STEP_LENGTH, ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF);
         load_register(CSR_COS_TURN, short_word(($urandom_range(0, 1) == 0) ? -16384 : 16384));
         load_register(CSR_SIN_TURN, short_word(($urandom_range(0, 1) == 0) ? -16384 : 16384));
         load_register(CSR_START_X, ($urandom_range(0, 1) == 0) ? 32'h80000000 : 32'h7FFFFFFF);
         load_register(CSR_START_Y, ($urandom_range(0, 1) == 0) ? 32'h80000000 : 32'h7FFFFFFF);
         load_register(CSR_START_DIR_X, short_word(($urandom_range(0, 1) == 0) ? -16384 : 16384));
         load_register(CSR_START_DIR_Y, short_word(($urandom_range(0, 1) == 0) ? -16384 : 16384));
      end else begin
         load_register(CSR_STEP_LENGTH, $urandom);
         load_register(CSR_COS_TURN, short_word(rand_q14()));
         load_register(CSR_SIN_TURN, short_word(rand_q14()));
         load_register(CSR_START_X, $urandom);
         load_register(CSR_START_Y, $urandom);
         load_register(CSR_START_DIR_X, short_word(rand_q14()));
         load_register(CSR_START_DIR_Y, short_word(rand_q14()));
      end
      send_command(FUNC_BEGIN, 8'($urandom));
      for (int i = 0; i < count; i++)
         send_command(pick_command(), 8'($urandom));
      drain_block();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_commands();
      test_register_extremes();
      test_stack_full();
      test_random_phase(1'b0, 80);
      test_random_phase(1'b1, 80);
      test_random_phase(1'b0, 80);
      // Last part runs with no idling on either side
      idle_enable = 1'b0;
      test_random_phase(1'b0, 50);

      repeat (20) @(posedge clock);
      $display("run covered %0d commands, %0d register writes, %0d vertices checked",
               commands_sent, register_writes, vertices_checked);
      $display("pushes dropped on a full stack: %0d, pops dropped: %0d, mismatches: %0d",
               pushes_dropped, pops_dropped, mismatches);
      if (mismatches == 0 && pending_vertices.size() == 0) begin
         $display("[turtle_command_vertex_engine_unit] OK");
      end else begin
         $display("[turtle_command_vertex_engine_unit] ERROR");
      end
      $finish;
   end

endmodule
